[hdl/ali_pkg.sv]
// Shared types, codes and the control program of the array list block.
package ali_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int POS_W          = 7;
    localparam int VALUE_W        = 32;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_RETRIEVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic [1:0]               operation;
        logic [POS_W-1:0]         position;
        logic signed [VALUE_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [1:0]               status;
        logic [POS_W-1:0]         length;
        logic                     is_empty;
    } t_rsp;

    typedef struct packed {
        logic start;
        logic full;
        logic bad;
        logic ins;
        logic rem;
        logic ret;
        logic idx_le_pos;
        logic idx_end;
    } t_cond;

    localparam int PC_W   = 5;
    localparam int COND_W = 4;
    localparam int ACT_W  = 4;

    localparam logic [COND_W-1:0] C_ALWAYS     = 4'd0;
    localparam logic [COND_W-1:0] C_NOSTART    = 4'd1;
    localparam logic [COND_W-1:0] C_FULL       = 4'd2;
    localparam logic [COND_W-1:0] C_BAD        = 4'd3;
    localparam logic [COND_W-1:0] C_INS        = 4'd4;
    localparam logic [COND_W-1:0] C_REM        = 4'd5;
    localparam logic [COND_W-1:0] C_RET        = 4'd6;
    localparam logic [COND_W-1:0] C_IDX_LE_POS = 4'd7;
    localparam logic [COND_W-1:0] C_IDX_END    = 4'd8;
    localparam logic [COND_W-1:0] C_NEVER      = 4'd9;

    localparam logic [ACT_W-1:0] A_NONE        = 4'd0;
    localparam logic [ACT_W-1:0] A_IDX_COUNT   = 4'd1;
    localparam logic [ACT_W-1:0] A_RD_BELOW    = 4'd2;
    localparam logic [ACT_W-1:0] A_WR_SHIFT_DN = 4'd3;
    localparam logic [ACT_W-1:0] A_WR_NEW      = 4'd4;
    localparam logic [ACT_W-1:0] A_IDX_POSM1   = 4'd5;
    localparam logic [ACT_W-1:0] A_RD_ABOVE    = 4'd6;
    localparam logic [ACT_W-1:0] A_WR_SHIFT_UP = 4'd7;
    localparam logic [ACT_W-1:0] A_DEC         = 4'd8;
    localparam logic [ACT_W-1:0] A_RD_POS      = 4'd9;
    localparam logic [ACT_W-1:0] A_SET_FULL    = 4'd10;
    localparam logic [ACT_W-1:0] A_SET_BAD     = 4'd11;
    localparam logic [ACT_W-1:0] A_EMIT        = 4'd12;

    localparam logic [PC_W-1:0] P_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] P_CHK_FULL = 5'd1;
    localparam logic [PC_W-1:0] P_CHK_BAD  = 5'd2;
    localparam logic [PC_W-1:0] P_CHK_INS  = 5'd3;
    localparam logic [PC_W-1:0] P_CHK_REM  = 5'd4;
    localparam logic [PC_W-1:0] P_CHK_RET  = 5'd5;
    localparam logic [PC_W-1:0] P_NOP      = 5'd6;
    localparam logic [PC_W-1:0] P_INS_INIT = 5'd7;
    localparam logic [PC_W-1:0] P_INS_LOOP = 5'd8;
    localparam logic [PC_W-1:0] P_INS_RD   = 5'd9;
    localparam logic [PC_W-1:0] P_INS_WR   = 5'd10;
    localparam logic [PC_W-1:0] P_INS_PUT  = 5'd11;
    localparam logic [PC_W-1:0] P_REM_INIT = 5'd12;
    localparam logic [PC_W-1:0] P_REM_LOOP = 5'd13;
    localparam logic [PC_W-1:0] P_REM_RD   = 5'd14;
    localparam logic [PC_W-1:0] P_REM_WR   = 5'd15;
    localparam logic [PC_W-1:0] P_REM_FIN  = 5'd16;
    localparam logic [PC_W-1:0] P_FULL     = 5'd17;
    localparam logic [PC_W-1:0] P_BAD      = 5'd18;
    localparam logic [PC_W-1:0] P_RET_RD   = 5'd19;
    localparam logic [PC_W-1:0] P_EMIT     = 5'd20;

    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic [ACT_W-1:0]  act;
    } t_uword;

    // Next step is target when the condition holds, otherwise the following step.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            P_IDLE:     w = '{C_NOSTART,    P_IDLE,     A_NONE};
            P_CHK_FULL: w = '{C_FULL,       P_FULL,     A_NONE};
            P_CHK_BAD:  w = '{C_BAD,        P_BAD,      A_NONE};
            P_CHK_INS:  w = '{C_INS,        P_INS_INIT, A_NONE};
            P_CHK_REM:  w = '{C_REM,        P_REM_INIT, A_NONE};
            P_CHK_RET:  w = '{C_RET,        P_RET_RD,   A_NONE};
            P_NOP:      w = '{C_ALWAYS,     P_EMIT,     A_NONE};
            P_INS_INIT: w = '{C_NEVER,      P_IDLE,     A_IDX_COUNT};
            P_INS_LOOP: w = '{C_IDX_LE_POS, P_INS_PUT,  A_NONE};
            P_INS_RD:   w = '{C_NEVER,      P_IDLE,     A_RD_BELOW};
            P_INS_WR:   w = '{C_ALWAYS,     P_INS_LOOP, A_WR_SHIFT_DN};
            P_INS_PUT:  w = '{C_ALWAYS,     P_EMIT,     A_WR_NEW};
            P_REM_INIT: w = '{C_NEVER,      P_IDLE,     A_IDX_POSM1};
            P_REM_LOOP: w = '{C_IDX_END,    P_REM_FIN,  A_NONE};
            P_REM_RD:   w = '{C_NEVER,      P_IDLE,     A_RD_ABOVE};
            P_REM_WR:   w = '{C_ALWAYS,     P_REM_LOOP, A_WR_SHIFT_UP};
            P_REM_FIN:  w = '{C_ALWAYS,     P_EMIT,     A_DEC};
            P_FULL:     w = '{C_ALWAYS,     P_EMIT,     A_SET_FULL};
            P_BAD:      w = '{C_ALWAYS,     P_EMIT,     A_SET_BAD};
            P_RET_RD:   w = '{C_NEVER,      P_IDLE,     A_RD_POS};
            P_EMIT:     w = '{C_ALWAYS,     P_IDLE,     A_EMIT};
            default:    w = '{C_ALWAYS,     P_IDLE,     A_NONE};
        endcase
        return w;
    endfunction

endpackage

[hdl/ali_seq.sv]
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module ali_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ali_pkg::t_cond       i_cond,
    output logic [ali_pkg::ACT_W-1:0] o_act,
    output logic                 o_busy
);

    logic [ali_pkg::PC_W-1:0] r_pc;
    logic [ali_pkg::PC_W-1:0] n_pc;
    ali_pkg::t_uword          w_word;
    logic                     w_take;

    assign w_word = ali_pkg::ucode(r_pc);
    assign o_act  = w_word.act;
    assign o_busy = (r_pc != ali_pkg::P_IDLE);

    always_comb begin
        case (w_word.cond)
            ali_pkg::C_ALWAYS:     w_take = 1'b1;
            ali_pkg::C_NOSTART:    w_take = !i_cond.start;
            ali_pkg::C_FULL:       w_take = i_cond.full;
            ali_pkg::C_BAD:        w_take = i_cond.bad;
            ali_pkg::C_INS:        w_take = i_cond.ins;
            ali_pkg::C_REM:        w_take = i_cond.rem;
            ali_pkg::C_RET:        w_take = i_cond.ret;
            ali_pkg::C_IDX_LE_POS: w_take = i_cond.idx_le_pos;
            ali_pkg::C_IDX_END:    w_take = i_cond.idx_end;
            default:               w_take = 1'b0;
        endcase
    end

    assign n_pc = w_take ? w_word.target : r_pc + ali_pkg::PC_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ali_pkg::P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[hdl/array_list_insert_remove.sv]
// Top level of the array list: request decode, entry memory and the datapath driven by microcode.
//
//  Channel   Ports                   Transfer
//  request   start, busy, i_req      start high while busy is low
//  result    o_valid, o_rsp          o_valid high for one cycle
//
// After a transfer, busy stays high while the full and position checks, the operation and the
// result step run; an insert or a remove also shifts the entries that follow the position, and
// the memory is moved one entry per read and write step.
// The result appears in the first cycle with busy low, and a new request may start then.
// Reset empties the list; entry contents are not cleared and need no clearing pass.
// The receiver cannot stall, so a result is shown for exactly one cycle.
module array_list_insert_remove #(
    parameter int CAPACITY   = ali_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ali_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ali_pkg::t_req i_req,
    output logic          o_valid,
    output ali_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > ali_pkg::POS_W) ? CW : ali_pkg::POS_W;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];

    logic [1:0]            r_op;
    logic [KW-1:0]         r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CW-1:0]         r_count;
    logic [KW-1:0]         r_idx;
    logic [DATA_WIDTH-1:0] r_rd;
    logic [1:0]            r_status;
    logic                  r_show;

    logic [ali_pkg::ACT_W-1:0] w_act;
    ali_pkg::t_cond        w_cond;
    logic                  w_accept;
    logic [KW-1:0]         w_count_k;
    logic [KW-1:0]         w_idx_dn;
    logic [KW-1:0]         w_idx_up;
    logic [KW-1:0]         w_pos_m1;
    logic [63:0]           w_in_ext;
    logic signed [63:0]    w_rd_sx;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;

    ali_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_act   (w_act),
        .o_busy  (busy)
    );

    assign w_accept  = start && !busy;
    assign w_count_k = KW'(r_count);
    assign w_idx_dn  = r_idx - KW'(1);
    assign w_idx_up  = r_idx + KW'(1);
    assign w_pos_m1  = r_pos - KW'(1);
    assign w_in_ext  = {32'b0, i_req.item_value};
    assign w_rd_sx   = 64'(signed'(r_rd));

    always_comb begin
        w_cond.start      = start;
        w_cond.full       = (r_op == ali_pkg::OP_INSERT) && (r_count >= CW'(CAPACITY));
        w_cond.bad        = ((r_op == ali_pkg::OP_INSERT) && (r_pos > w_count_k))
                         || ((r_op inside {ali_pkg::OP_REMOVE, ali_pkg::OP_RETRIEVE})
                             && ((r_pos == '0) || (r_pos > w_count_k)));
        w_cond.ins        = (r_op == ali_pkg::OP_INSERT);
        w_cond.rem        = (r_op == ali_pkg::OP_REMOVE);
        w_cond.ret        = (r_op == ali_pkg::OP_RETRIEVE);
        w_cond.idx_le_pos = (r_idx <= r_pos);
        w_cond.idx_end    = (w_idx_up >= w_count_k);
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = r_rd;
        w_re    = 1'b0;
        w_raddr = w_idx_dn[AW-1:0];
        case (w_act)
            ali_pkg::A_RD_BELOW: begin
                w_re = 1'b1;
            end
            ali_pkg::A_RD_ABOVE: begin
                w_re    = 1'b1;
                w_raddr = w_idx_up[AW-1:0];
            end
            ali_pkg::A_RD_POS: begin
                w_re    = 1'b1;
                w_raddr = w_pos_m1[AW-1:0];
            end
            ali_pkg::A_WR_SHIFT_DN, ali_pkg::A_WR_SHIFT_UP: begin
                w_we = 1'b1;
            end
            ali_pkg::A_WR_NEW: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
                w_wdata = r_val;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (w_act == ali_pkg::A_EMIT);
            if (w_act == ali_pkg::A_WR_NEW) begin
                r_count <= r_count + CW'(1);
            end else if (w_act == ali_pkg::A_DEC) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_req.operation;
            r_pos    <= KW'(i_req.position);
            r_val    <= w_in_ext[DATA_WIDTH-1:0];
            r_status <= ali_pkg::ST_OK;
            r_show   <= 1'b0;
        end
        case (w_act)
            ali_pkg::A_IDX_COUNT:   r_idx <= w_count_k;
            ali_pkg::A_WR_SHIFT_DN: r_idx <= w_idx_dn;
            ali_pkg::A_IDX_POSM1:   r_idx <= w_pos_m1;
            ali_pkg::A_WR_SHIFT_UP: r_idx <= w_idx_up;
            ali_pkg::A_SET_FULL:    r_status <= ali_pkg::ST_FULL;
            ali_pkg::A_SET_BAD:     r_status <= ali_pkg::ST_BAD_INDEX;
            ali_pkg::A_RD_POS:      r_show <= 1'b1;
            ali_pkg::A_EMIT: begin
                o_rsp.read_value <= r_show ? w_rd_sx[ali_pkg::VALUE_W-1:0] : '0;
                o_rsp.status     <= r_status;
                o_rsp.length     <= ali_pkg::POS_W'(r_count);
                o_rsp.is_empty   <= (r_count == '0);
            end
            default: begin
            end
        endcase
    end

endmodule
